### design/lc3_instruction_decoder_macros.svh
// assertion macros shared by the lc3 decoder checker
// both expect clk and arst_n in the scope where they are used
`ifndef LC3_INSTRUCTION_DECODER_MACROS_SVH
`define LC3_INSTRUCTION_DECODER_MACROS_SVH

// same-cycle implication
`define LC3D_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lc3d assertion failed");

// next-cycle implication
`define LC3D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lc3d assertion failed");

`endif

### design/lc3d_pkg.sv
`timescale 1ns / 1ps

package lc3d_pkg;

	// register file addresses
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_ORIGIN = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	localparam logic [15:0] ORIGIN_RESET = 16'd0;
	localparam logic [15:0] LIMIT_RESET  = 16'd40;

	// lc3 opcodes, bits 15..12
	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LD   = 4'd2;
	localparam logic [3:0] OP_ST   = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDR  = 4'd6;
	localparam logic [3:0] OP_STR  = 4'd7;
	localparam logic [3:0] OP_RTI  = 4'd8;
	localparam logic [3:0] OP_NOT  = 4'd9;
	localparam logic [3:0] OP_LDI  = 4'd10;
	localparam logic [3:0] OP_STI  = 4'd11;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	// mnemonic codes on the result channel
	localparam logic [4:0] MN_BR    = 5'd0;
	localparam logic [4:0] MN_ADD   = 5'd1;
	localparam logic [4:0] MN_LD    = 5'd2;
	localparam logic [4:0] MN_ST    = 5'd3;
	localparam logic [4:0] MN_JSR   = 5'd4;
	localparam logic [4:0] MN_JSRR  = 5'd5;
	localparam logic [4:0] MN_AND   = 5'd6;
	localparam logic [4:0] MN_LDR   = 5'd7;
	localparam logic [4:0] MN_STR   = 5'd8;
	localparam logic [4:0] MN_RTI   = 5'd9;
	localparam logic [4:0] MN_NOT   = 5'd10;
	localparam logic [4:0] MN_LDI   = 5'd11;
	localparam logic [4:0] MN_STI   = 5'd12;
	localparam logic [4:0] MN_JMP   = 5'd13;
	localparam logic [4:0] MN_RET   = 5'd14;
	localparam logic [4:0] MN_LEA   = 5'd15;
	localparam logic [4:0] MN_GETC  = 5'd16;
	localparam logic [4:0] MN_HALT  = 5'd21;

	// trap vectors with a service routine
	localparam logic [7:0] TRAP_FIRST = 8'h20;
	localparam logic [7:0] TRAP_LAST  = 8'h25;

	localparam logic [2:0] RET_BASE = 3'd7;

endpackage

### design/lc3_instruction_decoder.sv
`timescale 1ns / 1ps

// lc3 instruction decoder
// input channel: in_valid / in_stall carry one 16-bit instruction_word per transfer.
// output channel: out_valid / out_stall carry one decoded result per transfer:
//   mnemonic, cond_flags, three register numbers, imm_mode, immediate and
//   the pc-relative target_address.
// apb port: origin at 0x0, instruction_limit at 0x4; writing origin reloads the
//   address counter and clears the decoded count. only write while idle.
// one instruction word is taken every cycle while in_stall is low; the word is
//   held in the input register, then its decoded result in the result register,
//   from which it is offered on the output channel.
// words past the limit, opcode 13 and unknown trap vectors give no result;
//   the last two still advance the address and the count.
// when out_stall is high and the result register holds a result, it keeps it, and
//   in_stall rises only if the input register also holds a word that has a result.
// reset: origin 0, limit 40, address counter 0, count 0, both stages empty.
module lc3_instruction_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [15:0]                   instruction_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [4:0]                    mnemonic,
	output logic [2:0]                    cond_flags,
	output logic [2:0]                    first_reg,
	output logic [2:0]                    second_reg,
	output logic [2:0]                    third_reg,
	output logic                          imm_mode,
	output logic signed [5:0]             immediate,
	output logic [15:0]                   target_address,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lc3d_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [15:0] origin_q;
	logic [15:0] limit_q;
	logic [15:0] addr_q;
	logic [15:0] count_q;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic [15:0] pc_s1;

	logic        valid_s2;
	logic [4:0]  mn_s2;
	logic [2:0]  cc_s2;
	logic [2:0]  r1_s2;
	logic [2:0]  r2_s2;
	logic [2:0]  r3_s2;
	logic        im_s2;
	logic [5:0]  imm_s2;
	logic [15:0] tgt_s2;

	logic        cfg_wr;
	logic        accept;
	logic        count_ok;
	logic        out_free;
	logic        s1_go;

	logic [4:0]  mn_d;
	logic [2:0]  cc_d;
	logic [2:0]  r1_d;
	logic [2:0]  r2_d;
	logic [2:0]  r3_d;
	logic        im_d;
	logic [5:0]  imm_d;
	logic [15:0] tgt_d;
	logic        has_res;
	logic        tgt_en;
	logic        off11;
	logic [15:0] offset;
	logic [7:0]  trap_idx;

	// apb access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			lc3d_pkg::REG_ORIGIN: prdata = {16'd0, origin_q};
			lc3d_pkg::REG_LIMIT:  prdata = {16'd0, limit_q};
			default:              prdata = 32'd0;
		endcase
	end

	// handshake
	assign out_free = !valid_s2 || !out_stall;
	assign s1_go    = !valid_s1 || out_free || !has_res;
	assign in_stall = !s1_go;
	assign accept   = in_valid && s1_go;
	assign count_ok = count_q < limit_q;

	// configuration and address state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= lc3d_pkg::ORIGIN_RESET;
			limit_q  <= lc3d_pkg::LIMIT_RESET;
			addr_q   <= lc3d_pkg::ORIGIN_RESET;
			count_q  <= 16'd0;
		end else if (cfg_wr && paddr[2] == lc3d_pkg::REG_ORIGIN) begin
			origin_q <= pwdata[15:0];
			addr_q   <= pwdata[15:0];
			count_q  <= 16'd0;
		end else if (cfg_wr && paddr[2] == lc3d_pkg::REG_LIMIT) begin
			limit_q <= pwdata[15:0];
		end else if (accept && count_ok) begin
			addr_q  <= addr_q + 16'd1;
			count_q <= count_q + 16'd1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_go) begin
			valid_s1 <= accept && count_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			word_s1 <= instruction_word;
			pc_s1   <= addr_q + 16'd1;
		end
	end

	// field decode
	always_comb begin
		mn_d     = lc3d_pkg::MN_BR;
		cc_d     = 3'd0;
		r1_d     = 3'd0;
		r2_d     = 3'd0;
		r3_d     = 3'd0;
		im_d     = 1'b0;
		imm_d    = 6'd0;
		has_res  = 1'b1;
		tgt_en   = 1'b0;
		off11    = 1'b0;
		trap_idx = word_s1[7:0] - lc3d_pkg::TRAP_FIRST;
		case (word_s1[15:12])
			lc3d_pkg::OP_BR: begin
				mn_d   = lc3d_pkg::MN_BR;
				cc_d   = word_s1[11:9];
				tgt_en = 1'b1;
			end
			lc3d_pkg::OP_LD: begin
				mn_d   = lc3d_pkg::MN_LD;
				r1_d   = word_s1[11:9];
				tgt_en = 1'b1;
			end
			lc3d_pkg::OP_ST: begin
				mn_d   = lc3d_pkg::MN_ST;
				r1_d   = word_s1[11:9];
				tgt_en = 1'b1;
			end
			lc3d_pkg::OP_LDI: begin
				mn_d   = lc3d_pkg::MN_LDI;
				r1_d   = word_s1[11:9];
				tgt_en = 1'b1;
			end
			lc3d_pkg::OP_STI: begin
				mn_d   = lc3d_pkg::MN_STI;
				r1_d   = word_s1[11:9];
				tgt_en = 1'b1;
			end
			lc3d_pkg::OP_LEA: begin
				mn_d   = lc3d_pkg::MN_LEA;
				r1_d   = word_s1[11:9];
				tgt_en = 1'b1;
			end
			lc3d_pkg::OP_ADD, lc3d_pkg::OP_AND: begin
				mn_d = (word_s1[15:12] == lc3d_pkg::OP_ADD) ? lc3d_pkg::MN_ADD
					: lc3d_pkg::MN_AND;
				r1_d = word_s1[11:9];
				r2_d = word_s1[8:6];
				im_d = word_s1[5];
				if (word_s1[5]) begin
					imm_d = {word_s1[4], word_s1[4:0]};
				end else begin
					r3_d = word_s1[2:0];
				end
			end
			lc3d_pkg::OP_JSR: begin
				if (word_s1[11]) begin
					mn_d   = lc3d_pkg::MN_JSR;
					tgt_en = 1'b1;
					off11  = 1'b1;
				end else begin
					mn_d = lc3d_pkg::MN_JSRR;
					r2_d = word_s1[8:6];
				end
			end
			lc3d_pkg::OP_LDR: begin
				mn_d  = lc3d_pkg::MN_LDR;
				r1_d  = word_s1[11:9];
				r2_d  = word_s1[8:6];
				imm_d = word_s1[5:0];
			end
			lc3d_pkg::OP_STR: begin
				mn_d  = lc3d_pkg::MN_STR;
				r1_d  = word_s1[11:9];
				r2_d  = word_s1[8:6];
				imm_d = word_s1[5:0];
			end
			lc3d_pkg::OP_RTI: begin
				mn_d = lc3d_pkg::MN_RTI;
			end
			lc3d_pkg::OP_NOT: begin
				mn_d = lc3d_pkg::MN_NOT;
				r1_d = word_s1[11:9];
				r2_d = word_s1[8:6];
			end
			lc3d_pkg::OP_JMP: begin
				if (word_s1[8:6] == lc3d_pkg::RET_BASE) begin
					mn_d = lc3d_pkg::MN_RET;
				end else begin
					mn_d = lc3d_pkg::MN_JMP;
					r2_d = word_s1[8:6];
				end
			end
			lc3d_pkg::OP_TRAP: begin
				// only the six serviced vectors give a result
				if (word_s1[7:0] < lc3d_pkg::TRAP_FIRST
						|| word_s1[7:0] > lc3d_pkg::TRAP_LAST) begin
					has_res = 1'b0;
				end else begin
					mn_d = lc3d_pkg::MN_GETC + trap_idx[4:0];
				end
			end
			default: begin
				// reserved opcode
				has_res = 1'b0;
			end
		endcase
	end

	// pc-relative target, 9-bit or 11-bit offset
	assign offset = off11 ? {{5{word_s1[10]}}, word_s1[10:0]}
		: {{7{word_s1[8]}}, word_s1[8:0]};
	assign tgt_d  = tgt_en ? pc_s1 + offset : 16'd0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1 && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			mn_s2  <= mn_d;
			cc_s2  <= cc_d;
			r1_s2  <= r1_d;
			r2_s2  <= r2_d;
			r3_s2  <= r3_d;
			im_s2  <= im_d;
			imm_s2 <= imm_d;
			tgt_s2 <= tgt_d;
		end
	end

	assign out_valid      = valid_s2;
	assign mnemonic       = mn_s2;
	assign cond_flags     = cc_s2;
	assign first_reg      = r1_s2;
	assign second_reg     = r2_s2;
	assign third_reg      = r3_s2;
	assign imm_mode       = im_s2;
	assign immediate      = signed'(imm_s2);
	assign target_address = tgt_s2;

endmodule

### design/lc3d_checker.sv
`timescale 1ns / 1ps

`include "lc3_instruction_decoder_macros.svh"

module lc3d_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [4:0]        mnemonic,
	input logic [2:0]        first_reg,
	input logic [2:0]        second_reg,
	input logic              imm_mode,
	input logic signed [5:0] immediate,
	input logic [15:0]       target_address
);

	// a stalled result stays offered
	`LC3D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// mnemonic code stays at or below the halt code
	`LC3D_ASSERT_IMPL(a_mn_range, out_valid, mnemonic <= lc3d_pkg::MN_HALT)

	// ret carries no first or second register and no target
	`LC3D_ASSERT_IMPL(a_ret_clean, out_valid && mnemonic == lc3d_pkg::MN_RET,
		first_reg == 3'd0 && second_reg == 3'd0 && target_address == 16'd0)

	// immediate mode only on add and and
	`LC3D_ASSERT_IMPL(a_imm_op, out_valid && imm_mode,
		mnemonic == lc3d_pkg::MN_ADD || mnemonic == lc3d_pkg::MN_AND)

	// register-mode add and and have no immediate
	`LC3D_ASSERT_IMPL(a_reg_mode, out_valid && !imm_mode &&
		(mnemonic == lc3d_pkg::MN_ADD || mnemonic == lc3d_pkg::MN_AND), immediate == 6'sd0)

endmodule

bind lc3_instruction_decoder lc3d_checker u_lc3d_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.mnemonic       (mnemonic),
	.first_reg      (first_reg),
	.second_reg     (second_reg),
	.imm_mode       (imm_mode),
	.immediate      (immediate),
	.target_address (target_address)
);

### tb/lc3_decoder_checker.sv
`timescale 1ns / 1ps

// watches the instruction, result and register channels of the lc3 decoder,
// predicts every decoded result and compares it with what comes out
module lc3_decoder_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [15:0]                   instruction_word,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [4:0]                    mnemonic,
	input  logic [2:0]                    cond_flags,
	input  logic [2:0]                    first_reg,
	input  logic [2:0]                    second_reg,
	input  logic [2:0]                    third_reg,
	input  logic                          imm_mode,
	input  logic signed [5:0]             immediate,
	input  logic [15:0]                   target_address,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lc3d_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	input  logic [31:0]                   prdata,
	input  logic                          pready,
	output int                            failures,
	output int                            pending,
	output int                            decoded_results
);

	typedef struct packed {
		logic [4:0]  mnemonic;
		logic [2:0]  cond_flags;
		logic [2:0]  first_reg;
		logic [2:0]  second_reg;
		logic [2:0]  third_reg;
		logic        imm_mode;
		logic [5:0]  immediate;
		logic [15:0] target_address;
	} decode_t;

	// predicted register and counter state
	logic [15:0] origin_reg;
	logic [15:0] word_limit;
	logic [15:0] pc_count;
	logic [15:0] decoded_total;

	decode_t expected_decodes [$];

	// decode one word against the predicted state, 1 when it gives a result
	function automatic bit decode_word(input logic [15:0] w, output decode_t d);
		logic [3:0]  op;
		logic [15:0] pc;
		logic [15:0] off9;
		logic [15:0] off11;
		logic [7:0]  vec;
		logic [7:0]  trap_off;
		d = '0;
		op = w[15:12];
		off9 = {{7{w[8]}}, w[8:0]};
		off11 = {{5{w[10]}}, w[10:0]};
		vec = w[7:0];
		// past the limit the word leaves no trace
		if (decoded_total >= word_limit)
			return 0;
		decoded_total = decoded_total + 16'd1;
		pc_count = pc_count + 16'd1;
		pc = pc_count;
		case (op)
			lc3d_pkg::OP_BR: begin
				d.mnemonic = lc3d_pkg::MN_BR;
				d.cond_flags = w[11:9];
				d.target_address = pc + off9;
			end
			lc3d_pkg::OP_LD, lc3d_pkg::OP_ST, lc3d_pkg::OP_LDI, lc3d_pkg::OP_STI,
			lc3d_pkg::OP_LEA: begin
				case (op)
					lc3d_pkg::OP_LD:  d.mnemonic = lc3d_pkg::MN_LD;
					lc3d_pkg::OP_ST:  d.mnemonic = lc3d_pkg::MN_ST;
					lc3d_pkg::OP_LDI: d.mnemonic = lc3d_pkg::MN_LDI;
					lc3d_pkg::OP_STI: d.mnemonic = lc3d_pkg::MN_STI;
					default:          d.mnemonic = lc3d_pkg::MN_LEA;
				endcase
				d.first_reg = w[11:9];
				d.target_address = pc + off9;
			end
			lc3d_pkg::OP_ADD, lc3d_pkg::OP_AND: begin
				d.mnemonic = (op == lc3d_pkg::OP_ADD) ? lc3d_pkg::MN_ADD
					: lc3d_pkg::MN_AND;
				d.first_reg = w[11:9];
				d.second_reg = w[8:6];
				d.imm_mode = w[5];
				if (w[5])
					d.immediate = {w[4], w[4:0]};
				else
					d.third_reg = w[2:0];
			end
			lc3d_pkg::OP_JSR: begin
				if (w[11]) begin
					d.mnemonic = lc3d_pkg::MN_JSR;
					d.target_address = pc + off11;
				end else begin
					d.mnemonic = lc3d_pkg::MN_JSRR;
					d.second_reg = w[8:6];
				end
			end
			lc3d_pkg::OP_LDR, lc3d_pkg::OP_STR: begin
				d.mnemonic = (op == lc3d_pkg::OP_LDR) ? lc3d_pkg::MN_LDR
					: lc3d_pkg::MN_STR;
				d.first_reg = w[11:9];
				d.second_reg = w[8:6];
				d.immediate = w[5:0];
			end
			lc3d_pkg::OP_RTI: d.mnemonic = lc3d_pkg::MN_RTI;
			lc3d_pkg::OP_NOT: begin
				d.mnemonic = lc3d_pkg::MN_NOT;
				d.first_reg = w[11:9];
				d.second_reg = w[8:6];
			end
			lc3d_pkg::OP_JMP: begin
				// base register 7 is a return
				if (w[8:6] == lc3d_pkg::RET_BASE) begin
					d.mnemonic = lc3d_pkg::MN_RET;
				end else begin
					d.mnemonic = lc3d_pkg::MN_JMP;
					d.second_reg = w[8:6];
				end
			end
			lc3d_pkg::OP_TRAP: begin
				// unserviced vectors are counted but give nothing
				if (vec < lc3d_pkg::TRAP_FIRST || vec > lc3d_pkg::TRAP_LAST)
					return 0;
				trap_off = vec - lc3d_pkg::TRAP_FIRST;
				d.mnemonic = lc3d_pkg::MN_GETC + trap_off[4:0];
			end
			// reserved opcode: counted, no result
			default: return 0;
		endcase
		return 1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
		end
	endfunction

	// result transfers checked first, then the instruction and register channels
	always @(posedge clk or negedge arst_n) begin
		decode_t got;
		decode_t want;
		if (!arst_n) begin
			origin_reg = lc3d_pkg::ORIGIN_RESET;
			word_limit = lc3d_pkg::LIMIT_RESET;
			pc_count = lc3d_pkg::ORIGIN_RESET;
			decoded_total = 16'd0;
			expected_decodes.delete();
			failures = 0;
			pending = 0;
			decoded_results = 0;
		end else begin
			// result transfer
			if (out_valid && !out_stall) begin
				got.mnemonic = mnemonic;
				got.cond_flags = cond_flags;
				got.first_reg = first_reg;
				got.second_reg = second_reg;
				got.third_reg = third_reg;
				got.imm_mode = imm_mode;
				got.immediate = immediate;
				got.target_address = target_address;
				if (expected_decodes.size() == 0) begin
					failures++;
					$display("%0t: result with none expected, mnemonic %h target %h",
						$time, mnemonic, target_address);
				end else begin
					want = expected_decodes.pop_front();
					decoded_results++;
					check_field("mnemonic", 16'(want.mnemonic), 16'(got.mnemonic));
					check_field("cond_flags", 16'(want.cond_flags), 16'(got.cond_flags));
					check_field("first_reg", 16'(want.first_reg), 16'(got.first_reg));
					check_field("second_reg", 16'(want.second_reg), 16'(got.second_reg));
					check_field("third_reg", 16'(want.third_reg), 16'(got.third_reg));
					check_field("imm_mode", 16'(want.imm_mode), 16'(got.imm_mode));
					check_field("immediate", 16'(want.immediate), 16'(got.immediate));
					check_field("target_address", want.target_address, got.target_address);
				end
			end
			// instruction transfer
			if (in_valid && !in_stall) begin
				if (decode_word(instruction_word, want))
					expected_decodes.push_back(want);
			end
			// register access
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == lc3d_pkg::REG_ORIGIN) begin
						origin_reg = pwdata[15:0];
						pc_count = pwdata[15:0];
						decoded_total = 16'd0;
					end else begin
						word_limit = pwdata[15:0];
					end
				end else begin
					want.target_address = (paddr[2] == lc3d_pkg::REG_ORIGIN) ? origin_reg
						: word_limit;
					if (prdata !== {16'd0, want.target_address}) begin
						failures++;
						$display("%0t: register read at %h, expected %h got %h", $time,
							paddr, {16'd0, want.target_address}, prdata);
					end
				end
			end
			pending = expected_decodes.size();
		end
	end

endmodule

### tb/tb_lc3_instruction_decoder.sv
`timescale 1ns / 1ps

module tb_lc3_instruction_decoder;

	localparam logic [3:0] OP_RESERVED = 4'd13;
	localparam logic [lc3d_pkg::PADDR_W-1:0] ADDR_ORIGIN = {lc3d_pkg::REG_ORIGIN, 2'b00};
	localparam logic [lc3d_pkg::PADDR_W-1:0] ADDR_LIMIT  = {lc3d_pkg::REG_LIMIT, 2'b00};
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 64;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [15:0] instruction_word;
	logic out_valid;
	logic out_stall;
	logic [4:0] mnemonic;
	logic [2:0] cond_flags;
	logic [2:0] first_reg;
	logic [2:0] second_reg;
	logic [2:0] third_reg;
	logic imm_mode;
	logic signed [5:0] immediate;
	logic [15:0] target_address;
	logic psel;
	logic penable;
	logic pwrite;
	logic [lc3d_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	int failures;
	int pending;
	int decoded_results;
	int words_sent;
	int cycle_count;
	int hold_count;
	bit idle_enable;
	bit stall_enable;
	bit hold_off_req;
	bit hold_done;

	lc3_instruction_decoder i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .instruction_word(instruction_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.mnemonic(mnemonic), .cond_flags(cond_flags), .first_reg(first_reg),
		.second_reg(second_reg), .third_reg(third_reg), .imm_mode(imm_mode),
		.immediate(immediate), .target_address(target_address),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lc3_decoder_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .instruction_word(instruction_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.mnemonic(mnemonic), .cond_flags(cond_flags), .first_reg(first_reg),
		.second_reg(second_reg), .third_reg(third_reg), .imm_mode(imm_mode),
		.immediate(immediate), .target_address(target_address),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.failures(failures), .pending(pending), .decoded_results(decoded_results)
	);

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall bursts, and one long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(negedge clk);
					hold_count++;
				end
				out_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (stall_enable && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// mostly raw words, with extra weight on serviced traps and returns
	function automatic logic [15:0] random_word();
		logic [15:0] w;
		logic [3:0] junk;
		w = 16'($urandom_range(0, 65535));
		junk = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
			0: w = {lc3d_pkg::OP_TRAP, junk,
				lc3d_pkg::TRAP_FIRST + 8'($urandom_range(0, 5))};
			1: w = {lc3d_pkg::OP_JMP, w[11:9], lc3d_pkg::RET_BASE, w[5:0]};
			default: ;
		endcase
		return w;
	endfunction

	// one instruction transfer, called and returning at a falling edge
	task automatic send_word(input logic [15:0] w);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			instruction_word <= 16'($urandom_range(0, 65535));
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		instruction_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	// drain the block, then leave room for a word still in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// write a register, then read it back
	task automatic set_register(input logic [lc3d_pkg::PADDR_W-1:0] addr,
			input logic [15:0] value);
		for (int step = 0; step < 2; step++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= (step == 0);
			paddr <= addr;
			pwdata <= {16'd0, value};
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			@(negedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		instruction_word = 16'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		words_sent = 0;
		idle_enable = 1'b1;
		stall_enable = 1'b1;
		hold_off_req = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limit of 40, every opcode and the edge cases
		set_register(ADDR_ORIGIN, 16'h0000);
		send_word({lc3d_pkg::OP_BR, 3'b111, 9'h0FF});
		send_word({lc3d_pkg::OP_BR, 3'b000, 9'h100});
		send_word({lc3d_pkg::OP_ADD, 3'd7, 3'd7, 1'b1, 5'h10});
		send_word({lc3d_pkg::OP_ADD, 3'd0, 3'd0, 1'b0, 2'b11, 3'd7});
		send_word({lc3d_pkg::OP_AND, 3'd5, 3'd2, 1'b1, 5'h0F});
		send_word({lc3d_pkg::OP_AND, 3'd1, 3'd6, 1'b0, 2'b00, 3'd3});
		send_word({lc3d_pkg::OP_LD, 3'd7, 9'h1FF});
		send_word({lc3d_pkg::OP_ST, 3'd0, 9'h000});
		send_word({lc3d_pkg::OP_JSR, 1'b1, 11'h400});
		send_word({lc3d_pkg::OP_JSR, 1'b1, 11'h3FF});
		send_word({lc3d_pkg::OP_JSR, 1'b0, 2'b11, 3'd5, 6'h3F});
		send_word({lc3d_pkg::OP_LDR, 3'd3, 3'd4, 6'h20});
		send_word({lc3d_pkg::OP_STR, 3'd4, 3'd3, 6'h1F});
		send_word({lc3d_pkg::OP_RTI, 12'hFFF});
		send_word({lc3d_pkg::OP_NOT, 3'd2, 3'd5, 6'h3F});
		send_word({lc3d_pkg::OP_LDI, 3'd6, 9'h155});
		send_word({lc3d_pkg::OP_STI, 3'd1, 9'h0AA});
		send_word({lc3d_pkg::OP_JMP, 3'b111, 3'd2, 6'h3F});
		send_word({lc3d_pkg::OP_JMP, 3'b000, lc3d_pkg::RET_BASE, 6'h00});
		send_word({OP_RESERVED, 12'hABC});
		send_word({lc3d_pkg::OP_LEA, 3'd4, 9'h180});
		send_word({lc3d_pkg::OP_TRAP, 4'hF, lc3d_pkg::TRAP_FIRST});
		send_word({lc3d_pkg::OP_TRAP, 4'h0, lc3d_pkg::TRAP_LAST});
		send_word({lc3d_pkg::OP_TRAP, 4'h0, lc3d_pkg::TRAP_FIRST - 8'd1});
		send_word({lc3d_pkg::OP_TRAP, 4'h5, lc3d_pkg::TRAP_LAST + 8'd1});
		send_word({lc3d_pkg::OP_TRAP, 4'h0, 8'hFF});
		// runs past the limit
		repeat (24) send_word(random_word());

		// top origin so the address wraps, widest limit
		wait_idle();
		set_register(ADDR_ORIGIN, 16'hFFFF);
		set_register(ADDR_LIMIT, 16'hFFFF);
		for (int i = 0; i < 600; i++) begin
			if (i == 150)
				hold_off_req = 1'b1;
			if (i == 350) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			send_word(random_word());
		end

		// zero limit: nothing decodes
		wait_idle();
		set_register(ADDR_LIMIT, 16'h0000);
		repeat (8) send_word(random_word());

		// small limit after an origin reload
		wait_idle();
		set_register(ADDR_ORIGIN, 16'h8000);
		set_register(ADDR_LIMIT, 16'd5);
		repeat (10) send_word(random_word());

		// final stretch at full rate
		wait_idle();
		idle_enable = 1'b0;
		stall_enable = 1'b0;
		set_register(ADDR_ORIGIN, 16'($urandom_range(0, 65535)));
		set_register(ADDR_LIMIT, 16'hFFFF);
		repeat (380) send_word(random_word());

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d instruction words sent across five register settings", words_sent);
		$display("%0d decoded results checked, %0d mismatches", decoded_results, failures);
		if (failures == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
